// ===== rtl/core/ipipwm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipipwm_pkg
// Shared types, constants and helpers for the incremental PI current loop.
// ----------------------------------------------------------------------------
package ipipwm_pkg;

  // Significant bits of each current sample (sign-extended to 32 bits)
  localparam int MEAS_WIDTH = 32;

  // Fixed-point shifts: gains are Q20 on Q14 samples, duty scales Q20
  localparam int GAIN_SHIFT = 14;
  localparam int DUTY_SHIFT = 20;

  // Register file
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD    = 3'd4;

  localparam logic [30:0]        RST_PROP_GAIN     = 31'd50331;
  localparam logic [30:0]        RST_INTEGRAL_GAIN = 31'd12907;
  localparam logic signed [31:0] RST_OUTPUT_MIN    = 32'sd104857;
  localparam logic signed [31:0] RST_OUTPUT_MAX    = 32'sd943718;
  localparam logic [15:0]        RST_PWM_PERIOD    = 16'd1500;

  // Input beat
  typedef struct packed {
    logic signed [31:0] measured_current;
    logic signed [31:0] reference_current;
  } in_t;

  // Output beat
  typedef struct packed {
    logic [15:0]        compare_value;
    logic [15:0]        duty_count;
    logic signed [31:0] control_output;
  } out_t;

  // Configuration register contents
  typedef struct packed {
    logic [30:0]        prop_gain;
    logic [30:0]        integral_gain;
    logic signed [31:0] output_min;
    logic signed [31:0] output_max;
    logic [15:0]        pwm_period;
  } cfg_t;

  // Operand pair for the shared multiplier
  typedef enum logic [1:0] {
    MUL_INT,
    MUL_PROP,
    MUL_DUTY
  } mul_sel_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_I,
    S_MUL_P,
    S_SUM,
    S_ACCUM,
    S_CLAMP,
    S_MUL_D,
    S_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     load_err;
    logic     load_diff;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     sum_load;
    logic     sum_add;
    logic     acc_add;
    logic     acc_clamp;
    logic     load_out;
  } cmd_t;

  // Keep the low MEAS_WIDTH bits of a sample, sign-extended
  function automatic logic signed [31:0] narrow_meas(input logic signed [31:0] x);
    logic signed [31:0] t;
    t = x <<< (32 - MEAS_WIDTH);
    return t >>> (32 - MEAS_WIDTH);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/incremental_pi_current_loop_pwm.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// incremental_pi_current_loop_pwm
// Velocity-form PI current regulator producing a PWM compare value.
// ----------------------------------------------------------------------------
// Each sample steps through the sequencer in turn: the accepting cycle
// forms the error, then come three passes through the single shared 33x33
// multiplier (integral term, proportional term, duty scaling) and a state
// each for the term sum, the accumulate, the clamp and the output load,
// which puts the result into the output register.
// That shared multiplier and the sequencer around it set the rate. A new
// sample is taken once the previous one has reached the output register; if
// that register still holds an untaken beat, the finished result waits in
// place until it drains. Configuration writes take effect on the next cycle
// and are meant to be made while no sample is in flight.
module incremental_pi_current_loop_pwm (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire ipipwm_pkg::in_t                   in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output ipipwm_pkg::out_t                       out_data,
  input  wire logic                              cfg_we,
  input  wire logic [ipipwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ipipwm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ipipwm_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  // Configuration registers
  ipipwm_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencer
  ipipwm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Datapath
  ipipwm_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/core/ipipwm_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipipwm_regs
// Write-only configuration registers: gains, clamp limits and PWM period.
// ----------------------------------------------------------------------------
module ipipwm_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [ipipwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ipipwm_pkg::CFG_DATA_W-1:0] cfg_data,
  output ipipwm_pkg::cfg_t                      cfg
);
  import ipipwm_pkg::*;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain     <= RST_PROP_GAIN;
      cfg.integral_gain <= RST_INTEGRAL_GAIN;
      cfg.output_min    <= RST_OUTPUT_MIN;
      cfg.output_max    <= RST_OUTPUT_MAX;
      cfg.pwm_period    <= RST_PWM_PERIOD;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROP_GAIN:     cfg.prop_gain     <= cfg_data[30:0];
        REG_INTEGRAL_GAIN: cfg.integral_gain <= cfg_data[30:0];
        REG_OUTPUT_MIN:    cfg.output_min    <= cfg_data;
        REG_OUTPUT_MAX:    cfg.output_max    <= cfg_data;
        REG_PWM_PERIOD:    cfg.pwm_period    <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ipipwm_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipipwm_ctrl
// Sequencer: steps one sample through the datapath and owns output valid.
// ----------------------------------------------------------------------------
module ipipwm_ctrl (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output ipipwm_pkg::cmd_t cmd
);
  import ipipwm_pkg::*;

  state_t state, state_next;
  logic   out_free;
  logic   out_valid_next;

  // Output register can take a beat this cycle
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_MUL_I;
      S_MUL_I: state_next = S_MUL_P;
      S_MUL_P: state_next = S_SUM;
      S_SUM:   state_next = S_ACCUM;
      S_ACCUM: state_next = S_CLAMP;
      S_CLAMP: state_next = S_MUL_D;
      S_MUL_D: state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    cmd.mul_sel = MUL_INT;
    case (state)
      S_IDLE:  cmd.load_err = in_valid;
      S_MUL_I: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_INT;
        cmd.load_diff = 1'b1;
      end
      S_MUL_P: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_PROP;
        cmd.sum_load = 1'b1;
      end
      S_SUM:   cmd.sum_add   = 1'b1;
      S_ACCUM: cmd.acc_add   = 1'b1;
      S_CLAMP: cmd.acc_clamp = 1'b1;
      S_MUL_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DUTY;
      end
      S_DONE:  cmd.load_out = out_free;
      default: begin
      end
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // A result never overwrites a beat still waiting downstream
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result loaded over a pending beat");

  // A finished result waits while the output is blocked
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !out_ready) |=> (state == S_DONE))
    else $error("sequencer left done with output blocked");

  // An accepted sample starts the integral multiply
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_MUL_I))
    else $error("accepted sample did not start");

endmodule
`default_nettype wire

// ===== rtl/core/ipipwm_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipipwm_dp
// Datapath: error terms, shared multiplier, accumulator, clamp, PWM scaling.
// ----------------------------------------------------------------------------
module ipipwm_dp (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ipipwm_pkg::cfg_t cfg,
  input  wire ipipwm_pkg::cmd_t cmd,
  input  wire ipipwm_pkg::in_t  in_data,
  output ipipwm_pkg::out_t      out_data
);
  import ipipwm_pkg::*;

  logic signed [31:0] err;
  logic signed [31:0] prev_err;
  logic signed [31:0] diff;
  logic signed [63:0] prod;
  logic signed [31:0] sum;
  logic signed [31:0] acc;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_full;
  logic signed [31:0] term;
  logic               gt_max, lt_min;
  logic signed [31:0] acc_clamped;
  logic [15:0]        duty;

  // Shared multiplier operand select (gains and period are unsigned)
  always_comb begin
    case (cmd.mul_sel)
      MUL_INT: begin
        mul_a = {err[31], err};
        mul_b = {2'b00, cfg.integral_gain};
      end
      MUL_PROP: begin
        mul_a = {diff[31], diff};
        mul_b = {2'b00, cfg.prop_gain};
      end
      MUL_DUTY: begin
        mul_a = {acc[31], acc};
        mul_b = {17'd0, cfg.pwm_period};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // Floor shift of the product down to Q20, kept to 32 bits
  assign term = prod[GAIN_SHIFT+31:GAIN_SHIFT];

  // Upper clamp first, then lower; an inverted window ends at the minimum
  assign gt_max      = acc > cfg.output_max;
  assign lt_min      = gt_max ? (cfg.output_max < cfg.output_min) : (acc < cfg.output_min);
  assign acc_clamped = lt_min ? cfg.output_min : (gt_max ? cfg.output_max : acc);

  assign duty = prod[DUTY_SHIFT+15:DUTY_SHIFT];

  // Loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err <= '0;
      acc      <= '0;
    end else begin
      if (cmd.load_diff) prev_err <= err;
      if (cmd.acc_add) acc <= acc + sum;
      else if (cmd.acc_clamp) acc <= acc_clamped;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load_err)
      err <= narrow_meas(in_data.measured_current) - narrow_meas(in_data.reference_current);
    if (cmd.load_diff) diff <= err - prev_err;
    if (cmd.mul_en) prod <= mul_full[63:0];
    if (cmd.sum_load) sum <= term;
    else if (cmd.sum_add) sum <= sum + term;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.compare_value  <= cfg.pwm_period - duty;
      out_data.duty_count     <= duty;
      out_data.control_output <= acc;
    end
  end

  // After a clamp with an ordered window the accumulator lies inside it
  a_clamp_window: assert property (@(posedge clk) disable iff (rst)
    ($past(cmd.acc_clamp) && $stable(cfg) && (cfg.output_min <= cfg.output_max))
    |-> (acc >= cfg.output_min && acc <= cfg.output_max))
    else $error("accumulator outside clamp window");

  // The delivered output matches the accumulator it was taken from
  a_out_acc: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.load_out) |-> (out_data.control_output == acc))
    else $error("control output differs from accumulator");

endmodule
`default_nettype wire
